// File: sv/object_reference_scanner_macros.svh
// Assertion macros shared by the object reference scanner RTL.
`ifndef OBJECT_REFERENCE_SCANNER_MACROS_SVH
`define OBJECT_REFERENCE_SCANNER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ORS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ORS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ors_pkg.sv
// Constants, types and helper functions for the object reference scanner.
package ors_pkg;

    localparam int VALUE_BITS = 31;
    localparam int WIDE_BITS  = VALUE_BITS + 4;
    localparam int TDATA_W    = ((2 * VALUE_BITS + 7) / 8) * 8;
    localparam int TUSER_W    = 2;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_J     = 8'h6A;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_REF  = 2'd1,
        KIND_HDR  = 2'd2
    } kind_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // v*10 + digit, saturating; the low nibble of an ASCII digit is its value
    function automatic logic [VALUE_BITS-1:0] acc_digit(input logic [VALUE_BITS-1:0] v,
                                                        input logic [7:0]            c);
        logic [WIDE_BITS-1:0] wide;
        logic [WIDE_BITS-1:0] sum;
        wide = WIDE_BITS'(v);
        sum  = (wide << 3) + (wide << 1) + WIDE_BITS'(c[3:0]);
        if (sum > WIDE_BITS'(VALUE_MAX))
            return VALUE_MAX;
        return sum[VALUE_BITS-1:0];
    endfunction

endpackage

// File: sv/object_reference_scanner.sv
// Byte-stream scanner for "N G R" references and "N G obj" headers.
//
// Channel   Dir  Beat contents
// s_axis    in   tdata: text_char[7:0]; tlast: end_of_text
// m_axis    out  tuser: is_reference, is_header; tdata: object_number, generation
//
// One byte per cycle: each accepted beat steps the phase machine and the
// multiply-by-ten accumulators in the same cycle. The beat marked tlast loads
// the result register and returns the scanner to its start state, so the
// next string may begin with the following beat. A waiting result stalls the
// input only while m_axis_tready is low. rst_n clears all state asynchronously.
module object_reference_scanner
    import ors_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] text_char
    input  logic               s_axis_tlast,   // end_of_text
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // object_number, generation, zero pad
    output logic [TUSER_W-1:0] m_axis_tuser    // [0] is_reference, [1] is_header
);

    typedef enum logic [3:0] {
        PH_WS1  = 4'd0,
        PH_SGN1 = 4'd1,
        PH_DIG1 = 4'd2,
        PH_WS2  = 4'd3,
        PH_SGN2 = 4'd4,
        PH_DIG2 = 4'd5,
        PH_WS3  = 4'd6,
        PH_O    = 4'd7,
        PH_OB   = 4'd8,
        PH_DONE = 4'd9,
        PH_FAIL = 4'd10
    } phase_t;

    // scan state
    phase_t                phase_reg,  phase_next;
    logic                  neg_reg,    neg_next;
    logic [VALUE_BITS-1:0] first_reg,  first_next;
    logic [VALUE_BITS-1:0] second_reg, second_next;
    kind_t                 kind_reg,   kind_next;

    // result register
    logic                  out_valid_reg;
    logic                  is_ref_reg;
    logic                  is_hdr_reg;
    logic [VALUE_BITS-1:0] obj_num_reg;
    logic [VALUE_BITS-1:0] gen_reg;

    logic                  in_beat;
    logic [7:0]            c;
    logic                  c_space;
    logic                  c_digit;
    logic                  do_gap;
    logic                  do_suffix;
    logic                  matched;
    logic [VALUE_BITS-1:0] digit_val;
    logic [VALUE_BITS-1:0] first_acc;
    logic [VALUE_BITS-1:0] second_acc;

    assign c             = s_axis_tdata;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign c_space       = is_space(c);
    assign c_digit       = is_digit(c);
    assign digit_val     = VALUE_BITS'(c[3:0]);       // first digit of a number
    assign first_acc     = acc_digit(first_reg, c);
    assign second_acc    = acc_digit(second_reg, c);

    // one step of the phase machine for the byte on the input
    always_comb
    begin
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        first_next  = first_reg;
        second_next = second_reg;
        kind_next   = kind_reg;
        do_gap      = 1'b0;
        do_suffix   = 1'b0;

        if (c == CH_NUL)
        begin
            // terminator freezes the decision
            if (phase_reg != PH_DONE)
                phase_next = PH_FAIL;
        end
        else
        begin
            case (phase_reg)
                PH_WS1:
                begin
                    if (c_space)
                        phase_next = PH_WS1;
                    else if (c == CH_PLUS)
                        phase_next = PH_SGN1;
                    else if (c_digit)
                    begin
                        first_next = digit_val;
                        phase_next = PH_DIG1;
                    end
                    else
                        phase_next = PH_FAIL;   // '-' too: object number must be positive
                end
                PH_SGN1:
                begin
                    if (c_digit)
                    begin
                        first_next = digit_val;
                        phase_next = PH_DIG1;
                    end
                    else
                        phase_next = PH_FAIL;
                end
                PH_DIG1:
                begin
                    if (c_digit)
                        first_next = first_acc;
                    else if (first_reg == '0)
                        phase_next = PH_FAIL;
                    else
                        do_gap = 1'b1;
                end
                PH_WS2:
                    do_gap = 1'b1;
                PH_SGN2:
                begin
                    if (c_digit)
                    begin
                        second_next = digit_val;
                        phase_next  = PH_DIG2;
                    end
                    else
                        phase_next = PH_FAIL;
                end
                PH_DIG2:
                begin
                    if (c_digit)
                        second_next = second_acc;
                    else if (neg_reg && (second_reg != '0))
                        phase_next = PH_FAIL;   // only minus zero survives
                    else
                        do_suffix = 1'b1;
                end
                PH_WS3:
                    do_suffix = 1'b1;
                PH_O:
                    phase_next = (c == CH_B) ? PH_OB : PH_FAIL;
                PH_OB:
                begin
                    if (c == CH_J)
                    begin
                        kind_next  = KIND_HDR;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_FAIL;
                end
                default:
                    phase_next = phase_reg;     // done or failed: ignore the rest
            endcase
        end

        // gap between the numbers
        if (do_gap)
        begin
            if (c_space)
                phase_next = PH_WS2;
            else if (c == CH_MINUS)
            begin
                neg_next   = 1'b1;
                phase_next = PH_SGN2;
            end
            else if (c == CH_PLUS)
            begin
                neg_next   = 1'b0;
                phase_next = PH_SGN2;
            end
            else if (c_digit)
            begin
                neg_next    = 1'b0;
                second_next = digit_val;
                phase_next  = PH_DIG2;
            end
            else
                phase_next = PH_FAIL;
        end

        // whitespace or suffix after the generation
        if (do_suffix)
        begin
            if (c_space)
                phase_next = PH_WS3;
            else if (c == CH_R)
            begin
                kind_next  = KIND_REF;
                phase_next = PH_DONE;
            end
            else if (c == CH_O)
                phase_next = PH_O;
            else
                phase_next = PH_FAIL;
        end
    end

    assign matched = (phase_next == PH_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WS1;
            neg_reg       <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            kind_reg      <= KIND_NONE;
            out_valid_reg <= 1'b0;
            is_ref_reg    <= 1'b0;
            is_hdr_reg    <= 1'b0;
            obj_num_reg   <= '0;
            gen_reg       <= '0;
        end
        else
        begin
            if (in_beat && s_axis_tlast)
            begin
                // end of string: publish and start afresh
                out_valid_reg <= 1'b1;
                is_ref_reg    <= matched && (kind_next == KIND_REF);
                is_hdr_reg    <= matched && (kind_next == KIND_HDR);
                obj_num_reg   <= matched ? first_next  : '0;
                gen_reg       <= matched ? second_next : '0;
                phase_reg     <= PH_WS1;
                neg_reg       <= 1'b0;
                first_reg     <= '0;
                second_reg    <= '0;
                kind_reg      <= KIND_NONE;
            end
            else
            begin
                if (m_axis_tready)
                    out_valid_reg <= 1'b0;
                if (in_beat)
                begin
                    phase_reg  <= phase_next;
                    neg_reg    <= neg_next;
                    first_reg  <= first_next;
                    second_reg <= second_next;
                    kind_reg   <= kind_next;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {is_hdr_reg, is_ref_reg};

    always_comb
    begin
        m_axis_tdata                              = '0;
        m_axis_tdata[VALUE_BITS-1:0]              = obj_num_reg;
        m_axis_tdata[2*VALUE_BITS-1:VALUE_BITS]   = gen_reg;
    end

    // checks
`include "object_reference_scanner_macros.svh"

    `ORS_ASSERT_IMP(a_one_kind, clk, rst_n, out_valid_reg, !(is_ref_reg && is_hdr_reg), "both kinds flagged")
    `ORS_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid_reg && !is_ref_reg && !is_hdr_reg, (obj_num_reg == '0) && (gen_reg == '0), "numbers not cleared on miss")
    `ORS_ASSERT_IMP(a_obj_pos, clk, rst_n, out_valid_reg && (is_ref_reg || is_hdr_reg), obj_num_reg != '0, "zero object number matched")
    `ORS_ASSERT_NXT(a_last_restart, clk, rst_n, in_beat && s_axis_tlast, out_valid_reg && (phase_reg == PH_WS1) && (kind_reg == KIND_NONE), "last beat did not publish and restart")

endmodule

// File: bench/tb_object_reference_scanner.sv
// Self-checking bench for the object reference scanner: random strings against a local scan model.
module tb_object_reference_scanner
    import ors_pkg::*;
();

    localparam int          NUM_W         = VALUE_BITS + 4;  // room for v*10 + 9
    localparam int unsigned RANDOM_BYTES  = 720;
    localparam int unsigned SETTLE_CYCLES = 8;     // result is registered on the tlast beat
    localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no beat moving

    // bytes that steer the scanner, mixed into the noise strings
    localparam logic [7:0] PROBE_CHARS [10] = '{CH_SPACE, CH_ZERO, CH_NINE, CH_PLUS, CH_MINUS,
                                                CH_R, CH_O, CH_B, CH_J, CH_NUL};

    // scan position of the local model
    typedef enum logic [3:0] {
        SC_LEAD,     // leading whitespace
        SC_SIGN_A,   // '+' before the object number
        SC_NUM_A,    // object number digits
        SC_GAP,      // whitespace between the numbers
        SC_SIGN_B,   // sign before the generation
        SC_NUM_B,    // generation digits
        SC_TAIL,     // whitespace before the suffix
        SC_SEEN_O,
        SC_SEEN_OB,
        SC_MATCHED,
        SC_REJECT
    } scan_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic                  is_ref;
        logic                  is_hdr;
        logic [VALUE_BITS-1:0] obj_num;
        logic [VALUE_BITS-1:0] gen_num;
    } verdict_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;   // [7:0] text_char
    logic               s_axis_tlast = 1'b0; // end_of_text
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // [30:0] object_number, [61:31] generation, pad
    logic [TUSER_W-1:0] m_axis_tuser;        // [0] is_reference, [1] is_header

    beat_t       text_beats[$];        // bytes waiting to be driven
    verdict_t    awaited_verdicts[$];  // results owed by the scanner, oldest first
    logic [7:0]  text_buf[$];          // string under construction
    int unsigned queued_bytes = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatches = 0;
    int unsigned stall_count = 0;

    // local scan model state
    scan_t                 scan_st = SC_LEAD;
    logic                  neg_b = 1'b0;
    logic [VALUE_BITS-1:0] num_a = '0;
    logic [VALUE_BITS-1:0] num_b = '0;
    kind_t                 found_kind = KIND_NONE;

    object_reference_scanner u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scan model
    // ------------------------------------------------------------------

    // space, TAB, LF, VT, FF, CR
    function automatic logic ws_char(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // append one decimal digit, pinned at the top of the value range
    function automatic logic [VALUE_BITS-1:0] times_ten_plus(input logic [VALUE_BITS-1:0] v,
                                                             input logic [7:0]            c);
        logic [NUM_W-1:0] grown;
        grown = NUM_W'(v) * NUM_W'(10) + NUM_W'(c - CH_ZERO);
        return (grown > NUM_W'(VALUE_MAX)) ? VALUE_MAX : grown[VALUE_BITS-1:0];
    endfunction

    task automatic clear_scan();
        scan_st    = SC_LEAD;
        neg_b      = 1'b0;
        num_a      = '0;
        num_b      = '0;
        found_kind = KIND_NONE;
    endtask

    // after a complete generation, or in the whitespace ahead of the suffix
    task automatic take_suffix(input logic [7:0] c);
        if (ws_char(c))
            scan_st = SC_TAIL;
        else if (c == CH_R)
        begin
            found_kind = KIND_REF;
            scan_st    = SC_MATCHED;
        end
        else if (c == CH_O)
            scan_st = SC_SEEN_O;
        else
            scan_st = SC_REJECT;
    endtask

    // ahead of the generation: whitespace, a sign, or straight into digits
    task automatic take_gap(input logic [7:0] c);
        if (ws_char(c))
            scan_st = SC_GAP;
        else if (c == CH_MINUS)
        begin
            neg_b   = 1'b1;
            scan_st = SC_SIGN_B;
        end
        else if (c == CH_PLUS)
        begin
            neg_b   = 1'b0;
            scan_st = SC_SIGN_B;
        end
        else if (digit_char(c))
        begin
            neg_b   = 1'b0;
            num_b   = times_ten_plus('0, c);
            scan_st = SC_NUM_B;
        end
        else
            scan_st = SC_REJECT;
    endtask

    task automatic scan_char(input logic [7:0] c);
        // a NUL freezes whatever has been decided so far
        if (c == CH_NUL)
        begin
            if (scan_st != SC_MATCHED)
                scan_st = SC_REJECT;
        end
        else
        begin
            case (scan_st)
                SC_LEAD:
                    if (!ws_char(c))
                    begin
                        // no '-' here: a negative object number can never be above zero
                        if (c == CH_PLUS)
                            scan_st = SC_SIGN_A;
                        else if (digit_char(c))
                        begin
                            num_a   = times_ten_plus('0, c);
                            scan_st = SC_NUM_A;
                        end
                        else
                            scan_st = SC_REJECT;
                    end
                SC_SIGN_A:
                    if (digit_char(c))
                    begin
                        num_a   = times_ten_plus('0, c);
                        scan_st = SC_NUM_A;
                    end
                    else
                        scan_st = SC_REJECT;
                SC_NUM_A:
                    if (digit_char(c))
                        num_a = times_ten_plus(num_a, c);
                    else if (num_a == '0)
                        scan_st = SC_REJECT;
                    else
                        take_gap(c);
                SC_GAP:
                    take_gap(c);
                SC_SIGN_B:
                    if (digit_char(c))
                    begin
                        num_b   = times_ten_plus('0, c);
                        scan_st = SC_NUM_B;
                    end
                    else
                        scan_st = SC_REJECT;
                SC_NUM_B:
                    if (digit_char(c))
                        num_b = times_ten_plus(num_b, c);
                    else if (neg_b && num_b != '0)
                        scan_st = SC_REJECT;   // only "-0" survives as a signed generation
                    else
                        take_suffix(c);
                SC_TAIL:
                    take_suffix(c);
                SC_SEEN_O:
                    scan_st = (c == CH_B) ? SC_SEEN_OB : SC_REJECT;
                SC_SEEN_OB:
                    if (c == CH_J)
                    begin
                        found_kind = KIND_HDR;
                        scan_st    = SC_MATCHED;
                    end
                    else
                        scan_st = SC_REJECT;
                default:
                    ;   // matched or rejected: rest of the string is ignored
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // String building
    // ------------------------------------------------------------------

    task automatic put_text(input string s);
        foreach (s[i])
            text_buf.push_back(s[i]);
    endtask

    task automatic put_ws(input int unsigned n);
        repeat (n)
            text_buf.push_back(($urandom_range(0, 2) == 0) ? CH_SPACE
                                                           : 8'($urandom_range(CH_TAB, CH_CR)));
    endtask

    task automatic put_sign(input int unsigned neg_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < neg_pct)
            text_buf.push_back(CH_MINUS);
        else if (r < neg_pct + 20)
            text_buf.push_back(CH_PLUS);
    endtask

    // mostly short numbers; now and then long enough to saturate
    task automatic put_number();
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
        repeat (n)
            text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // move the built string into the send queue, tlast on its final byte
    task automatic flush_text();
        foreach (text_buf[i])
            text_beats.push_back('{ch: text_buf[i], last: (i == text_buf.size() - 1)});
        queued_bytes += text_buf.size();
        text_buf.delete();
    endtask

    task automatic put_random_text();
        int unsigned form;
        int unsigned pos;
        form = $urandom_range(0, 99);
        if (form < 15)
        begin
            // noise: raw bytes with a fair share of meaningful ones
            repeat ($urandom_range(1, 8))
                text_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                        : PROBE_CHARS[$urandom_range(0, 9)]);
        end
        else
        begin
            put_ws($urandom_range(0, 2));
            put_sign(5);
            put_number();
            if ($urandom_range(0, 3) == 0)
                put_sign(50);          // numbers run together unless a sign splits them
            else
            begin
                put_ws($urandom_range(1, 2));
                put_sign(10);
            end
            put_number();
            put_ws($urandom_range(0, 2));
            if ($urandom_range(0, 1))
                text_buf.push_back(CH_R);
            else
            begin
                text_buf.push_back(CH_O);
                text_buf.push_back(CH_B);
                text_buf.push_back(CH_J);
            end
            repeat ($urandom_range(0, 3))
                text_buf.push_back(8'($urandom_range(0, 255)));
            // damage some of the well-formed strings
            if (form >= 80)
            begin
                pos = $urandom_range(0, text_buf.size() - 1);
                case ($urandom_range(0, 3))
                    0:       text_buf[pos] = 8'($urandom_range(0, 255));
                    1:       text_buf[pos] = CH_NUL;
                    2:       while (text_buf.size() > pos + 1)
                                 void'(text_buf.pop_back());
                    default: text_buf.delete(pos);
                endcase
            end
        end
        flush_text();
    endtask

    task automatic put_random_run(input int unsigned n_bytes);
        int unsigned start;
        start = queued_bytes;
        while (queued_bytes - start < n_bytes)
            put_random_text();
    endtask

    // hold off until every byte is in and every result out, then let the scanner settle
    task automatic drain();
        while (text_beats.size() != 0 || s_axis_tvalid || awaited_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Byte driver: one beat per handshake, model stepped on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : feed_text
        verdict_t verdict;
        beat_t    nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                scan_char(s_axis_tdata);
                if (s_axis_tlast)
                begin
                    // numbers only reported when a form matched
                    verdict.is_ref  = scan_st == SC_MATCHED && found_kind == KIND_REF;
                    verdict.is_hdr  = scan_st == SC_MATCHED && found_kind == KIND_HDR;
                    verdict.obj_num = (scan_st == SC_MATCHED) ? num_a : '0;
                    verdict.gen_num = (scan_st == SC_MATCHED) ? num_b : '0;
                    awaited_verdicts.push_back(verdict);
                    clear_scan();
                end
            end
            // free to present the next byte, or to idle
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (text_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = text_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.ch;
                    s_axis_tlast  <= nxt.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : watch_results
        verdict_t want;
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    $display("%0t: expected no result, got tuser %0h tdata %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = awaited_verdicts.pop_front();
                    check_field("is_reference", want.is_ref, m_axis_tuser[0]);
                    check_field("is_header", want.is_hdr, m_axis_tuser[1]);
                    check_field("object_number", want.obj_num, m_axis_tdata[VALUE_BITS-1:0]);
                    check_field("generation", want.gen_num,
                                m_axis_tdata[2*VALUE_BITS-1:VALUE_BITS]);
                    check_field("tdata padding", '0, m_axis_tdata[TDATA_W-1:2*VALUE_BITS]);
                end
            end
        end
    end

    // watchdog: any beat on either side restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_count <= 0;
            else if (stall_count >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
            else
                stall_count <= stall_count + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase one: slow sender, heavily stalled receiver
        send_idle_pct = 24;
        recv_idle_pct = 87;

        // directed strings
        put_text("12 0 R");                      flush_text();   // plain reference
        put_text("  +7 3 obj");                  flush_text();   // header, signed object
        put_text("5-0 R");                       flush_text();   // "-0" generation, no gap
        put_text("8 -00 obj");                   flush_text();
        put_text("5 -3 R");                      flush_text();   // negative generation
        put_text("-5 0 R");                      flush_text();   // negative object number
        put_text("0 0 R");                       flush_text();   // zero object number
        put_text("99999999999 88888888888 obj"); flush_text();   // both saturate
        put_text("2147483647 2147483647 R");     flush_text();   // exactly full scale
        put_text("007 00 obj");                  flush_text();   // leading zeros
        put_text("1 +2 R");                      flush_text();
        put_text("4 2 Rxyz");                    flush_text();   // junk after suffix
        put_text(" \0113\012\013+1\014\015obj"); flush_text();   // every whitespace byte
        put_text("1 2 o");                       flush_text();   // incomplete suffixes
        put_text("1 2 ob");                      flush_text();
        put_text("1 2 ox");                      flush_text();
        put_text("1 2");                         flush_text();   // no suffix at all
        put_text("+ 1 2 R");                     flush_text();   // sign then space
        put_text("3 4 R");                                        // NUL after a match
        text_buf.push_back(CH_NUL);
        put_text("zz");                          flush_text();
        put_text("3 4");                                          // NUL before the suffix
        text_buf.push_back(CH_NUL);
        put_text(" R");                          flush_text();
        text_buf.push_back(CH_NUL);              flush_text();   // lone NUL
        put_text("R");                           flush_text();   // lone suffix
        put_text("1 2 R");                                        // top-bit byte after match
        text_buf.push_back(8'hFF);               flush_text();

        put_random_run(RANDOM_BYTES / 3);
        drain();

        // phase two: sender mostly idle, receiver mostly ready
        send_idle_pct = 87;
        recv_idle_pct = 24;
        put_random_run(RANDOM_BYTES / 3);
        drain();

        // phase three: back to back on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        put_random_run(RANDOM_BYTES / 3);
        drain();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
